// ===== sv/ectm_pkg.sv =====
package ectm_pkg;

  localparam int unsigned DEF_MAX_TRACKS = 64;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned ETA_W  = 16;
  localparam int unsigned PHI_W  = 15;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CONE_W = 32;

  localparam logic [CONE_W-1:0] CONE_RST = 32'd2684354;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // pi and 2*pi at 4096 per radian
  localparam int PI_FX     = 12868;
  localparam int TWO_PI_FX = 25736;

  localparam int unsigned CMDQ_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LOAD,
    CMD_QUERY
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [ETA_W-1:0]  eta;
    logic signed [PHI_W-1:0]  phi;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_WALK,
    BE_FINISH
  } be_state_e;

endpackage

// ===== sv/ectm_front.sv =====
module ectm_front import ectm_pkg::*; (
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic signed [ETA_W-1:0]  eta_i,
  input  logic signed [PHI_W-1:0]  phi_i,
  input  q_status_t                q_status_i,
  output logic                     push_o,
  output cmd_t                     cmd_o
);

  logic known;

  always_comb begin
    in_ready_o = !q_status_i.full;
    cmd_o.eta  = eta_i;
    cmd_o.phi  = phi_i;
    cmd_o.cmd  = CMD_CLEAR;
    known      = 1'b1;
    case (kind_i)
      KIND_CLEAR: cmd_o.cmd = CMD_CLEAR;
      KIND_LOAD:  cmd_o.cmd = CMD_LOAD;
      KIND_QUERY: cmd_o.cmd = CMD_QUERY;
      // reserved kind: transaction taken and discarded
      default:    known = 1'b0;
    endcase
    push_o = in_valid_i && in_ready_o && known;
  end

endmodule

// ===== sv/ectm_cmd_fifo.sv =====
module ectm_cmd_fifo import ectm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      data_i,
  input  logic      pop_i,
  output cmd_t      data_o,
  output q_status_t status_o
);

  localparam int unsigned PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          mem_q [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(CMDQ_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    status_o.full  = (cnt_q == CW'(CMDQ_DEPTH));
    status_o.empty = (cnt_q == '0);
    do_push        = push_i && !status_o.full;
    do_pop         = pop_i && !status_o.empty;
    data_o         = mem_q[rd_ptr_q];
    wr_ptr_d       = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d       = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/ectm_back.sv =====
module ectm_back import ectm_pkg::*; #(
  parameter int unsigned MAX_TRACKS = DEF_MAX_TRACKS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CONE_W-1:0] cone_i,
  input  cmd_t              cmd_i,
  input  q_status_t         q_status_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              matched_o,
  output logic [IDX_W-1:0]  track_index_o,
  output logic              last_o,
  output logic              dropped_o
);

  localparam int unsigned AW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned CW    = $clog2(MAX_TRACKS + 1);
  localparam int unsigned DPA_W = $clog2(PI_FX + 1);
  localparam int unsigned SQE_W = 2 * ETA_W;
  localparam int unsigned SQP_W = 2 * DPA_W;
  localparam logic signed [PHI_W:0] PI_S     = (PHI_W + 1)'(PI_FX);
  localparam logic signed [PHI_W:0] TWO_PI_S = (PHI_W + 1)'(TWO_PI_FX);

  be_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] issue_q, issue_d;
  logic          issue, issue_last, adv;

  logic signed [ETA_W-1:0] jet_eta_q;
  logic signed [PHI_W-1:0] jet_phi_q;
  logic                    jet_ld;

  logic [ETA_W-1:0] eta_mem [MAX_TRACKS];
  logic [PHI_W-1:0] phi_mem [MAX_TRACKS];
  logic             mem_we;

  // stage 1: table read, stage 2: squares, compare on stage 2 outputs
  logic                    s1_valid_q, s1_last_q;
  logic [AW-1:0]           s1_idx_q;
  logic signed [ETA_W-1:0] s1_eta_q;
  logic signed [PHI_W-1:0] s1_phi_q;

  logic             s2_valid_q, s2_last_q;
  logic [AW-1:0]    s2_idx_q;
  logic [SQE_W-1:0] s2_sqe_q, s2_sqe_d;
  logic [SQP_W-1:0] s2_sqp_q, s2_sqp_d;

  logic signed [ETA_W:0] de;
  logic signed [PHI_W:0] dp_raw, dp;
  logic [ETA_W-1:0]      de_abs;
  logic [DPA_W-1:0]      dp_abs;
  logic [SQE_W:0]        dr2;
  logic                  hit;

  logic          pend_valid_q, pend_valid_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;

  logic          emit, e_matched, e_last, e_drop;
  logic [AW-1:0] e_idx;

  logic          out_valid_q, out_matched_q, out_last_q, out_dropped_q;
  logic [AW-1:0] out_idx_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign issue      = (state_q == BE_WALK) && (issue_q < count_q);
  assign issue_last = ((issue_q + CW'(1)) == count_q);

  always_comb begin
    de     = {jet_eta_q[ETA_W-1], jet_eta_q} - {s1_eta_q[ETA_W-1], s1_eta_q};
    dp_raw = {jet_phi_q[PHI_W-1], jet_phi_q} - {s1_phi_q[PHI_W-1], s1_phi_q};
    // one correction suffices for any 15-bit operands
    if (dp_raw >= PI_S) begin
      dp = dp_raw - TWO_PI_S;
    end else if (dp_raw < -PI_S) begin
      dp = dp_raw + TWO_PI_S;
    end else begin
      dp = dp_raw;
    end
    de_abs   = de[ETA_W] ? ETA_W'(-de) : de[ETA_W-1:0];
    dp_abs   = dp[PHI_W] ? DPA_W'(-dp) : DPA_W'(dp);
    s2_sqe_d = de_abs * de_abs;
    s2_sqp_d = dp_abs * dp_abs;
    dr2      = {1'b0, s2_sqe_q} + (SQE_W + 1)'(s2_sqp_q);
    hit      = s2_valid_q && (dr2 < (SQE_W + 1)'(cone_i));
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (adv) begin
      case (state_q)
        BE_IDLE: begin
          if (!q_status_i.empty && cmd_i.cmd == CMD_QUERY) begin
            state_d = (count_q == '0) ? BE_FINISH : BE_WALK;
          end
        end
        BE_WALK: begin
          if (s2_valid_q && s2_last_q) begin
            state_d = BE_FINISH;
          end
        end
        BE_FINISH: state_d = BE_IDLE;
        default:   state_d = BE_IDLE;
      endcase
    end
  end

  // outputs and datapath control
  always_comb begin
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    jet_ld       = 1'b0;
    emit         = 1'b0;
    e_matched    = 1'b0;
    e_idx        = '0;
    e_last       = 1'b0;
    e_drop       = 1'b0;
    count_d      = count_q;
    issue_d      = issue_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    if (adv) begin
      case (state_q)
        BE_IDLE: begin
          if (!q_status_i.empty) begin
            pop_o = 1'b1;
            case (cmd_i.cmd)
              CMD_CLEAR: count_d = '0;
              CMD_LOAD: begin
                emit = 1'b1;
                if (count_q >= CW'(MAX_TRACKS)) begin
                  e_drop = 1'b1;
                end else begin
                  mem_we  = 1'b1;
                  count_d = count_q + CW'(1);
                end
              end
              CMD_QUERY: begin
                jet_ld  = 1'b1;
                issue_d = '0;
              end
              default: ;
            endcase
          end
        end
        BE_WALK: begin
          if (issue) begin
            issue_d = issue_q + CW'(1);
          end
          // a match is held back one step so the final one can carry last
          if (hit) begin
            pend_valid_d = 1'b1;
            pend_idx_d   = s2_idx_q;
            if (pend_valid_q) begin
              emit      = 1'b1;
              e_matched = 1'b1;
              e_idx     = pend_idx_q;
            end
          end
        end
        BE_FINISH: begin
          emit         = 1'b1;
          e_matched    = pend_valid_q;
          e_idx        = pend_valid_q ? pend_idx_q : '0;
          e_last       = 1'b1;
          pend_valid_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BE_IDLE;
      count_q      <= '0;
      issue_q      <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      issue_q      <= issue_d;
      pend_valid_q <= pend_valid_d;
      if (adv) begin
        s1_valid_q  <= issue;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    if (jet_ld) begin
      jet_eta_q <= cmd_i.eta;
      jet_phi_q <= cmd_i.phi;
    end
    if (adv) begin
      s1_last_q <= issue_last;
      s1_idx_q  <= issue_q[AW-1:0];
      s2_last_q <= s1_last_q;
      s2_idx_q  <= s1_idx_q;
      s2_sqe_q  <= s2_sqe_d;
      s2_sqp_q  <= s2_sqp_d;
      if (emit) begin
        out_matched_q <= e_matched;
        out_idx_q     <= e_idx;
        out_last_q    <= e_last;
        out_dropped_q <= e_drop;
      end
    end
  end

  // track table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      eta_mem[count_q[AW-1:0]] <= cmd_i.eta;
      phi_mem[count_q[AW-1:0]] <= cmd_i.phi;
    end
    if (adv && issue) begin
      s1_eta_q <= eta_mem[issue_q[AW-1:0]];
      s1_phi_q <= phi_mem[issue_q[AW-1:0]];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign matched_o     = out_matched_q;
  assign track_index_o = IDX_W'(out_idx_q);
  assign last_o        = out_last_q;
  assign dropped_o     = out_dropped_q;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TRACKS))
    else $error("track count above table depth");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_WALK) |-> (issue_q <= count_q))
    else $error("walk read pointer beyond track count");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_IDLE) |-> (!pend_valid_q && !s2_valid_q))
    else $error("query residue left in idle");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_FINISH && adv) |=> (out_valid_q && out_last_q))
    else $error("query end did not produce a last result");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_IDLE && pop_o && cmd_i.cmd == CMD_LOAD &&
     count_q == CW'(MAX_TRACKS)) |=> (out_dropped_q && $stable(count_q)))
    else $error("load into full table not flagged as dropped");
`endif

endmodule

// ===== sv/eta_phi_cone_track_matcher_top.sv =====
// Delta-R cone matcher. Tracks (eta, phi, 4096 per unit) are appended to a
// table of MAX_TRACKS entries; a clear transaction empties it and every load
// returns a single result, with dropped set if the table was full. A jet
// query walks the stored tracks in load order and returns one result per
// track with deta^2 + dphi^2 (dphi wrapped into [-pi, pi)) strictly below
// cone_radius_squared, the final one with last set, or a single no-match
// result with last set. Input transactions go into a four-entry command
// queue, so the input side keeps accepting until it is full while results
// are stalled. Clear and load execute straight from idle; a query reads the
// track table through its single read port, one track per cycle while
// results are not stalled, into a two-stage read-and-square pipeline, then
// a closing step ends the query (an empty table goes straight to it). The
// table needs no clearing after reset.
// Radius writes take effect at once and are meant for idle periods.
module eta_phi_cone_track_matcher_top import ectm_pkg::*; #(
  parameter int unsigned MAX_TRACKS = DEF_MAX_TRACKS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CONE_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [KIND_W-1:0]        in_kind_i,
  input  logic signed [ETA_W-1:0]  in_eta_i,
  input  logic signed [PHI_W-1:0]  in_phi_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     out_matched_o,
  output logic [IDX_W-1:0]         out_track_index_o,
  output logic                     out_last_o,
  output logic                     out_dropped_o
);

  logic [CONE_W-1:0] cone_q;
  logic              push, pop;
  cmd_t              push_cmd, head_cmd;
  q_status_t         q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cone_q <= CONE_RST;
    end else if (cfg_we_i) begin
      cone_q <= cfg_wdata_i;
    end
  end

  ectm_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (in_kind_i),
    .eta_i      (in_eta_i),
    .phi_i      (in_phi_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ectm_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_cmd),
    .pop_i    (pop),
    .data_o   (head_cmd),
    .status_o (q_status)
  );

  ectm_back #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cone_i        (cone_q),
    .cmd_i         (head_cmd),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .matched_o     (out_matched_o),
    .track_index_o (out_track_index_o),
    .last_o        (out_last_o),
    .dropped_o     (out_dropped_o)
  );

endmodule

// ===== bench/tb_eta_phi_cone_track_matcher_top.sv =====
`timescale 1ns / 100ps

module tb_eta_phi_cone_track_matcher_top;
  import ectm_pkg::*;

  // kind 3 has no meaning; the block must swallow it without a result
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned SINK_HOLD      = 300;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic             matched;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             dropped;
  } hit_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CONE_W-1:0]       cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [KIND_W-1:0]       in_kind_i = KIND_CLEAR;
  logic signed [ETA_W-1:0] in_eta_i = '0;
  logic signed [PHI_W-1:0] in_phi_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    out_matched_o;
  logic [IDX_W-1:0]        out_track_index_o;
  logic                    out_last_o;
  logic                    out_dropped_o;

  // predictor state
  logic [CONE_W-1:0]       cone_r2 = CONE_RST;
  logic signed [ETA_W-1:0] trk_eta [DEF_MAX_TRACKS];
  logic signed [PHI_W-1:0] trk_phi [DEF_MAX_TRACKS];
  int unsigned             trk_cnt = 0;
  hit_t                    pending_hits[$];

  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  int unsigned sink_hold = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;

  eta_phi_cone_track_matcher_top #(
    .MAX_TRACKS(DEF_MAX_TRACKS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_kind_i         (in_kind_i),
    .in_eta_i          (in_eta_i),
    .in_phi_i          (in_phi_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_matched_o     (out_matched_o),
    .out_track_index_o (out_track_index_o),
    .out_last_o        (out_last_o),
    .out_dropped_o     (out_dropped_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // appends one expected result at the tail
  function automatic void queue_hit(hit_t h);
    pending_hits.insert(pending_hits.size(), h);
  endfunction

  // Works out the results one accepted transaction should give and queues them.
  function automatic void predict_cone_hits(logic [KIND_W-1:0] kind,
                                            logic signed [ETA_W-1:0] eta,
                                            logic signed [PHI_W-1:0] phi);
    longint deta, dphi, r2;
    hit_t   held, h;
    bit     have_held;
    have_held = 1'b0;
    held = '0;
    h = '0;
    case (kind)
      KIND_CLEAR: trk_cnt = 0;
      KIND_LOAD: begin
        if (trk_cnt >= DEF_MAX_TRACKS) begin
          h.dropped = 1'b1;
        end else begin
          trk_eta[trk_cnt] = eta;
          trk_phi[trk_cnt] = phi;
          trk_cnt++;
        end
        queue_hit(h);
      end
      KIND_QUERY: begin
        for (int i = 0; i < trk_cnt; i++) begin
          deta = eta - trk_eta[i];
          dphi = phi - trk_phi[i];
          while (dphi >= PI_FX) dphi -= TWO_PI_FX;
          while (dphi < -PI_FX) dphi += TWO_PI_FX;
          r2 = deta * deta + dphi * dphi;
          if (r2 < longint'(cone_r2)) begin
            // hold each hit back one step so the final one can carry last
            if (have_held) queue_hit(held);
            held = '0;
            held.matched = 1'b1;
            held.idx = i[IDX_W-1:0];
            have_held = 1'b1;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          queue_hit(held);
        end else begin
          h.last = 1'b1;
          queue_hit(h);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_failure(string what, hit_t want, hit_t got);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("%0t %s: exp m=%0b i=%0d l=%0b d=%0b, got m=%0b i=%0d l=%0b d=%0b",
               $time, what, want.matched, want.idx, want.last, want.dropped,
               got.matched, got.idx, got.last, got.dropped);
  endfunction

  // predict first, then check, so a same-edge result can never race its prediction
  always @(posedge clk_i) begin : monitor_p
    hit_t want, got;
    if (rst_ni && in_valid_i && in_ready_o)
      predict_cone_hits(in_kind_i, in_eta_i, in_phi_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.matched = out_matched_o;
      got.idx = out_track_index_o;
      got.last = out_last_o;
      got.dropped = out_dropped_o;
      if (pending_hits.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = pending_hits.pop_front();
        if (got.matched !== want.matched || got.idx !== want.idx ||
            got.last !== want.last || got.dropped !== want.dropped)
          note_failure("result mismatch", want, got);
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, pending_hits.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      out_ready_i <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (sink_idle_en) begin
      out_ready_i <= ($urandom_range(99) >= 8);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic int rand_eta();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // mostly inside [-pi, pi], sometimes anywhere in the 15-bit range
  function automatic int rand_phi();
    if ($urandom_range(99) < 85)
      return int'($urandom_range(2 * PI_FX)) - PI_FX;
    return int'($urandom_range(32767)) - 16384;
  endfunction

  function automatic int jitter(int unsigned span);
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input int eta, input int phi);
    @(negedge clk_i);
    while (src_idle_en && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i <= kind;
    in_eta_i <= eta[ETA_W-1:0];
    in_phi_i <= phi[PHI_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    if (kind != KIND_SPARE) items_sent++;
  endtask

  // drop valid, let every expected result come back, then give clears and
  // spare kinds still queued time to retire
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cone_radius(input logic [CONE_W-1:0] value);
    settle_block();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    cone_r2 = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One event: clear, some tracks, then jets that mostly sit near a track.
  task automatic run_event(input int n_loads, input int n_queries);
    int ev_eta[DEF_MAX_TRACKS];
    int ev_phi[DEF_MAX_TRACKS];
    int n_kept, k, c_eta, c_phi, e, p;
    bit clustered;
    n_kept = 0;
    clustered = 1'($urandom_range(1));
    c_eta = rand_eta();
    c_phi = rand_phi();
    send_item(KIND_CLEAR, rand_eta(), rand_phi());
    for (int i = 0; i < n_loads; i++) begin
      e = clustered ? c_eta + jitter(1500) : rand_eta();
      p = clustered ? c_phi + jitter(1500) : rand_phi();
      if (n_kept < DEF_MAX_TRACKS) begin
        ev_eta[n_kept] = e;
        ev_phi[n_kept] = p;
        n_kept++;
      end
      send_item(KIND_LOAD, e, p);
    end
    for (int j = 0; j < n_queries; j++) begin
      if (n_kept != 0 && $urandom_range(3) != 0) begin
        k = $urandom_range(n_kept - 1);
        send_item(KIND_QUERY, ev_eta[k] + jitter(1500), ev_phi[k] + jitter(1500));
      end else begin
        send_item(KIND_QUERY, rand_eta(), rand_phi());
      end
    end
  endtask

  task automatic test_directed();
    send_item(KIND_QUERY, 0, 0);                 // empty table
    send_item(KIND_SPARE, 32767, 16383);
    send_item(KIND_LOAD, 32767, 16383);
    send_item(KIND_LOAD, -32768, -16384);
    send_item(KIND_LOAD, 0, PI_FX);
    send_item(KIND_LOAD, 0, -PI_FX);
    send_item(KIND_LOAD, 100, 12800);
    send_item(KIND_LOAD, 0, 0);
    send_item(KIND_QUERY, 32767, 16383);
    send_item(KIND_QUERY, -32768, -16384);
    send_item(KIND_QUERY, 0, -12800);            // dphi wraps across pi
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_QUERY, -32768, 16383);        // largest deta and dphi
    send_item(KIND_SPARE, -1, -1);
    send_item(KIND_QUERY, 32767, -16384);
    send_item(KIND_CLEAR, 0, 0);
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_LOAD, -1, -1);
    send_item(KIND_QUERY, 0, 0);
  endtask

  task automatic test_cone_boundary();
    write_cone_radius(32'd1000000);
    send_item(KIND_CLEAR, 0, 0);
    send_item(KIND_LOAD, 0, 0);
    send_item(KIND_QUERY, 1000, 0);              // dR2 equal to radius: no hit
    send_item(KIND_QUERY, 999, 0);
    send_item(KIND_QUERY, -1000, 0);
    send_item(KIND_QUERY, 0, 999);
    send_item(KIND_QUERY, 0, -1000);
    send_item(KIND_LOAD, 0, PI_FX);
    send_item(KIND_QUERY, 0, -PI_FX);            // difference of exactly 2*pi
    write_cone_radius('0);
    send_item(KIND_QUERY, 0, 0);                 // nothing can be below zero
    write_cone_radius('1);
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_QUERY, -32768, -16384);
  endtask

  task automatic test_full_table();
    // two loads beyond capacity are dropped; wide radius gives long queries
    run_event(DEF_MAX_TRACKS + 2, 2);
    send_item(KIND_LOAD, rand_eta(), rand_phi());
    send_item(KIND_QUERY, rand_eta(), rand_phi());
  endtask

  task automatic test_random_events(input int unsigned n_items);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(99) < 10)
        send_item(KIND_W'($urandom_range(3)), rand_eta(), rand_phi());
      else
        run_event(($urandom_range(15) == 0) ? $urandom_range(40, 66) : $urandom_range(10),
                   $urandom_range(1, 4));
    end
  endtask

  task automatic test_no_idle(input int unsigned n_items);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random_events(n_items);
    settle_block();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    src_idle_en = 1'b0;
    @(posedge clk_i);
    sink_hold = SINK_HOLD;
    run_event(12, 8);
    src_idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_cone_boundary();
    test_full_table();
    write_cone_radius(CONE_RST);
    test_random_events(100);
    write_cone_radius($urandom_range(20000000));
    test_no_idle(80);
    test_backpressure();
    write_cone_radius($urandom);
    test_random_events(60);
    write_cone_radius($urandom_range(4000000, 12000000));
    test_random_events(80);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_hits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
